FILE: rtl/decimal_field_formatter_assert.svh
// Assertion macros used by the decimal field formatter back end.
`ifndef DECIMAL_FIELD_FORMATTER_ASSERT_SVH
`define DECIMAL_FIELD_FORMATTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DFF_ASSERT_IMP(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("decimal_field_formatter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DFF_ASSERT_NXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("decimal_field_formatter: next-cycle check failed");

`endif

FILE: rtl/dff_pkg.sv
// Shared types and constants of the decimal field formatter.
package dff_pkg;

    localparam int MAX_DIGITS_DEF = 10;

    localparam int COORD_W = 10;
    localparam int CHAR_X_W = 11;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 4;
    localparam int SIZE_W = 6;
    localparam int HALF_W = SIZE_W - 1;
    localparam int CODE_W = 6;
    localparam int BIT_CNT_W = $clog2(VALUE_W);

    localparam logic [CODE_W-1:0] CH_ZERO = CODE_W'(48);
    localparam logic [CODE_W-1:0] CH_SPACE = CODE_W'(32);

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic [HALF_W-1:0]  half_width;
        logic [SIZE_W-1:0]  glyph_size;
        logic               zero_fill;
    } dff_desc_t;

endpackage

FILE: rtl/decimal_field_formatter.sv
// Top level of the decimal field formatter.
// Each accepted item yields one character per decimal position, most significant first, with
// leading zeros shown as '0' or as a space; an item with a digit count of zero yields nothing.
// The back end takes an item from the queue, converts it by bit-serial binary to decimal
// conversion and then emits one character per cycle while the result register is free or
// being popped; it takes the next item only after the last character of the current one.
// A two-entry queue between front and back holds further items while one is being converted,
// and a result register holds the oldest character until popped.
module decimal_field_formatter
    import dff_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [COORD_W-1:0]  start_x,
    input  logic [COORD_W-1:0]  start_y,
    input  logic [VALUE_W-1:0]  value,
    input  logic [COUNT_W-1:0]  digit_count,
    input  logic [SIZE_W-1:0]   glyph_size,
    input  logic                zero_fill,
    output logic                empty,
    input  logic                pop,
    output logic [CODE_W-1:0]   char_code,
    output logic [CHAR_X_W-1:0] char_x,
    output logic [COORD_W-1:0]  char_y,
    output logic [SIZE_W-1:0]   char_size,
    output logic                last
);

    logic      desc_valid;
    logic      desc_take;
    dff_desc_t desc;

    dff_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .start_x     (start_x),
        .start_y     (start_y),
        .value       (value),
        .digit_count (digit_count),
        .glyph_size  (glyph_size),
        .zero_fill   (zero_fill),
        .desc_valid  (desc_valid),
        .desc        (desc),
        .desc_take   (desc_take)
    );

    dff_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_take  (desc_take),
        .empty      (empty),
        .pop        (pop),
        .char_code  (char_code),
        .char_x     (char_x),
        .char_y     (char_y),
        .char_size  (char_size),
        .last       (last)
    );

endmodule

FILE: rtl/dff_front.sv
// Input side: accepts items, saturates the digit count and queues the work.
module dff_front
    import dff_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [VALUE_W-1:0] value,
    input  logic [COUNT_W-1:0] digit_count,
    input  logic [SIZE_W-1:0]  glyph_size,
    input  logic               zero_fill,
    output logic               desc_valid,
    output dff_desc_t          desc,
    input  logic               desc_take
);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    dff_desc_t          queue_mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  fill_reg;
    logic [QCNT_W-1:0]  fill_next;
    logic [COUNT_W-1:0] count_sat;
    logic               enqueue;
    dff_desc_t          in_desc;

    assign full = (fill_reg == QCNT_W'(QDEPTH));
    assign desc_valid = (fill_reg != '0);
    assign desc = queue_mem[rd_ptr_reg];

    assign count_sat = (digit_count > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS)
                                                             : digit_count;

    // An item with a digit count of zero produces nothing and is dropped here.
    assign enqueue = push && !full && (count_sat != '0);

    always_comb
    begin
        in_desc.start_x    = start_x;
        in_desc.start_y    = start_y;
        in_desc.value      = value;
        in_desc.count      = count_sat;
        in_desc.half_width = glyph_size[SIZE_W-1:1];
        in_desc.glyph_size = glyph_size;
        in_desc.zero_fill  = zero_fill;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (enqueue)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (desc_take)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (enqueue && !desc_take)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (!enqueue && desc_take)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enqueue)
        begin
            queue_mem[wr_ptr_reg] <= in_desc;
        end
    end

endmodule

FILE: rtl/dff_back.sv
// Output side: bit-serial binary to decimal conversion and character emission.
module dff_back
    import dff_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                desc_valid,
    input  dff_desc_t           desc,
    output logic                desc_take,
    output logic                empty,
    input  logic                pop,
    output logic [CODE_W-1:0]   char_code,
    output logic [CHAR_X_W-1:0] char_x,
    output logic [COORD_W-1:0]  char_y,
    output logic [SIZE_W-1:0]   char_size,
    output logic                last
);

`include "decimal_field_formatter_assert.svh"

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    dff_desc_t             work_reg;
    dff_desc_t             work_next;
    logic [VALUE_W-1:0]    bin_reg;
    logic [VALUE_W-1:0]    bin_next;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic [BCD_W-1:0]      bcd_adj;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [BIT_CNT_W-1:0]  bit_cnt_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [CHAR_X_W-1:0]   x_reg;
    logic [CHAR_X_W-1:0]   x_next;
    logic                  shown_reg;
    logic                  shown_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [CODE_W-1:0]     code_reg;
    logic [CODE_W-1:0]     code_next;
    logic [CHAR_X_W-1:0]   cx_reg;
    logic [CHAR_X_W-1:0]   cx_next;
    logic [COORD_W-1:0]    cy_reg;
    logic [COORD_W-1:0]    cy_next;
    logic [SIZE_W-1:0]     cs_reg;
    logic [SIZE_W-1:0]     cs_next;
    logic                  last_reg;
    logic                  last_next;
    logic [3:0]            digits [MAX_DIGITS];
    logic [3:0]            cur_digit;
    logic                  final_pos;
    logic                  slot_free;

    assign empty     = !out_valid_reg;
    assign char_code = code_reg;
    assign char_x    = cx_reg;
    assign char_y    = cy_reg;
    assign char_size = cs_reg;
    assign last      = last_reg;

    assign desc_take = (state_reg == ST_IDLE) && desc_valid;
    assign slot_free = !out_valid_reg || pop;
    assign final_pos = (idx_reg == '0);

    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            digits[i] = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                            : bcd_reg[4*i +: 4];
        end
    end

    assign cur_digit = digits[idx_reg];

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        idx_next       = idx_reg;
        x_next         = x_reg;
        shown_next     = shown_reg;
        out_valid_next = out_valid_reg && !pop;
        code_next      = code_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cs_next        = cs_reg;
        last_next      = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (desc_valid)
                begin
                    work_next    = desc;
                    bin_next     = desc.value;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // Digits above the register's top drop out, leaving the value
                // modulo ten to the number of digits.
                bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next     = {bin_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                begin
                    idx_next   = IDX_W'(work_reg.count - COUNT_W'(1));
                    x_next     = CHAR_X_W'(work_reg.start_x);
                    shown_next = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (!shown_reg && !final_pos && (cur_digit == 4'd0))
                    begin
                        code_next = work_reg.zero_fill ? CH_ZERO : CH_SPACE;
                    end
                    else
                    begin
                        shown_next = 1'b1;
                        code_next  = CH_ZERO + CODE_W'(cur_digit);
                    end
                    cx_next   = x_reg;
                    cy_next   = work_reg.start_y;
                    cs_next   = work_reg.glyph_size;
                    last_next = final_pos;
                    x_next    = x_reg + CHAR_X_W'(work_reg.half_width);
                    idx_next  = idx_reg - IDX_W'(1);
                    if (final_pos)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            work_reg      <= '0;
            bin_reg       <= '0;
            bcd_reg       <= '0;
            bit_cnt_reg   <= '0;
            idx_reg       <= '0;
            x_reg         <= '0;
            shown_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            code_reg      <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cs_reg        <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            work_reg      <= work_next;
            bin_reg       <= bin_next;
            bcd_reg       <= bcd_next;
            bit_cnt_reg   <= bit_cnt_next;
            idx_reg       <= idx_next;
            x_reg         <= x_next;
            shown_reg     <= shown_next;
            out_valid_reg <= out_valid_next;
            code_reg      <= code_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            cs_reg        <= cs_next;
            last_reg      <= last_next;
        end
    end

    `DFF_ASSERT_IMP(a_idx_in_range, clk, rst_n, state_reg == ST_EMIT, (COUNT_W'(idx_reg) < work_reg.count))
    `DFF_ASSERT_IMP(a_code_legal, clk, rst_n, out_valid_reg, (code_reg == CH_SPACE) || ((code_reg >= CH_ZERO) && (code_reg <= CH_ZERO + CODE_W'(9))))
    `DFF_ASSERT_NXT(a_last_ends_item, clk, rst_n, (state_reg == ST_EMIT) && slot_free && final_pos, (state_reg == ST_IDLE) && last_reg && out_valid_reg)
    `DFF_ASSERT_IMP(a_space_before_digit, clk, rst_n, out_valid_reg && last_reg, code_reg != CH_SPACE)

endmodule
